[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/aclfrt_pkg.sv]
// Types, codes and constants for the ACL fragment reassembly tracker.
// No dependencies.
package aclfrt_pkg;

    localparam int HANDLE_W  = 12;
    localparam int CTX_DEPTH = 1 << HANDLE_W;
    localparam int LEN_W     = 16;

    localparam logic [1:0]       BFLAG_START    = 2'd2;
    localparam logic [LEN_W-1:0] PREAMBLE_BYTES = 16'd4;
    localparam logic [LEN_W-1:0] FRAME_HDR_BYTES = 16'd8;

    localparam logic [2:0] ACT_PASS      = 3'd0;
    localparam logic [2:0] ACT_WHOLE     = 3'd1;
    localparam logic [2:0] ACT_STARTED   = 3'd2;
    localparam logic [2:0] ACT_APPENDED  = 3'd3;
    localparam logic [2:0] ACT_COMPLETED = 3'd4;
    localparam logic [2:0] ACT_DROPPED   = 3'd5;

    typedef struct packed {
        logic             is_acl;
        logic [15:0]      handle_word;
        logic [LEN_W-1:0] acl_len;
        logic [LEN_W-1:0] l2cap_len;
    } hdr_t;

    typedef struct packed {
        logic [2:0]          action;
        logic [HANDLE_W-1:0] conn_handle;
        logic                dropped_old;
        logic                excess_data;
        logic                truncated;
        logic [LEN_W-1:0]    write_offset;
        logic [LEN_W-1:0]    copy_length;
        logic [LEN_W-1:0]    total_len;
        logic [LEN_W-1:0]    acl_patch_len;
    } res_t;

    typedef struct packed {
        logic             active;
        logic [LEN_W-1:0] exp_len;
        logic [LEN_W-1:0] fill_off;
    } ctx_entry_t;

    typedef struct packed {
        logic                clr_en;
        logic [HANDLE_W-1:0] clr_addr;
        logic                rd_en;
        logic                commit;
    } cmd_t;

    typedef struct packed {
        logic res_busy;
    } stat_t;

endpackage

[rtl/aclfrt_ctrl.sv]
// Sequencer: context clearing pass, header accept, result commit.
// Depends on aclfrt_pkg.
module aclfrt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hdr_valid,
    output logic                hdr_stall,
    input  aclfrt_pkg::stat_t   stat,
    output aclfrt_pkg::cmd_t    cmd
);
    import aclfrt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [HANDLE_W-1:0] clr_cnt_reg, clr_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd          = '0;
        cmd.clr_addr = clr_cnt_reg;
        hdr_stall    = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                hdr_stall  = 1'b0;
                cmd.rd_en  = hdr_valid;
                if (hdr_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!stat.res_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

[rtl/aclfrt_dp.sv]
// Datapath: context memory, header register, result logic, result register.
// Depends on aclfrt_pkg.
module aclfrt_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  aclfrt_pkg::hdr_t   hdr,
    input  aclfrt_pkg::cmd_t   cmd,
    output aclfrt_pkg::stat_t  stat,
    output logic               res_valid,
    input  logic               res_stall,
    output aclfrt_pkg::res_t   res
);
    import aclfrt_pkg::*;

    ctx_entry_t mem [CTX_DEPTH];
    ctx_entry_t rd_data_reg;
    hdr_t       hdr_reg;
    res_t       res_reg, res_next;
    logic       res_valid_reg, res_valid_next;

    ctx_entry_t          wr_ent;
    logic                wr_req;
    logic [HANDLE_W-1:0] hnd;
    logic [1:0]          bflag;
    logic [LEN_W-1:0]    plen, flen_s, proj0, room;

    always_comb
    begin
        hnd    = hdr_reg.handle_word[HANDLE_W-1:0];
        bflag  = hdr_reg.handle_word[13:12];
        plen   = hdr_reg.acl_len + PREAMBLE_BYTES;
        flen_s = hdr_reg.l2cap_len + FRAME_HDR_BYTES;
        proj0  = rd_data_reg.fill_off + hdr_reg.acl_len;
        room   = rd_data_reg.exp_len - rd_data_reg.fill_off;
        res_next = '0;
        wr_ent   = rd_data_reg;
        wr_req   = 1'b0;
        if (hdr_reg.is_acl)
        begin
            res_next.conn_handle = hnd;
            if (bflag == BFLAG_START)
            begin
                res_next.dropped_old = rd_data_reg.active;
                res_next.total_len   = flen_s;
                res_next.copy_length = plen;
                wr_req               = 1'b1;
                if (flen_s <= plen)
                begin
                    res_next.action      = ACT_WHOLE;
                    res_next.excess_data = (flen_s < plen);
                    wr_ent.active        = 1'b0;
                end
                else
                begin
                    res_next.action        = ACT_STARTED;
                    res_next.acl_patch_len = flen_s - PREAMBLE_BYTES;
                    wr_ent.active          = 1'b1;
                    wr_ent.exp_len         = flen_s;
                    wr_ent.fill_off        = plen;
                end
            end
            else if (!rd_data_reg.active)
            begin
                res_next.action = ACT_DROPPED;
            end
            else
            begin
                wr_req                 = 1'b1;
                res_next.write_offset  = rd_data_reg.fill_off;
                res_next.total_len     = rd_data_reg.exp_len;
                res_next.acl_patch_len = rd_data_reg.exp_len - PREAMBLE_BYTES;
                if (proj0 > rd_data_reg.exp_len)
                begin
                    res_next.truncated   = 1'b1;
                    res_next.copy_length = room;
                    wr_ent.fill_off      = rd_data_reg.exp_len;
                end
                else
                begin
                    res_next.copy_length = hdr_reg.acl_len;
                    wr_ent.fill_off      = proj0;
                end
                if (wr_ent.fill_off == rd_data_reg.exp_len)
                begin
                    res_next.action = ACT_COMPLETED;
                    wr_ent.active   = 1'b0;
                end
                else
                begin
                    res_next.action = ACT_APPENDED;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[cmd.clr_addr] <= '0;
        end
        else if (cmd.commit && wr_req)
        begin
            mem[hnd] <= wr_ent;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[hdr.handle_word[HANDLE_W-1:0]];
            hdr_reg     <= hdr;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign stat.res_busy = res_valid_reg && res_stall;
    assign res_valid     = res_valid_reg;
    assign res           = res_reg;

endmodule

[rtl/acl_fragment_reassembly_tracker.sv]
// An accepted header loads the header register and its context entry; the result is
// registered and the entry written back at commit; no new header is taken before it.
// While a finished result waits, one more header is taken and held until the output frees.
// Reset: clearing pass over all 4096 context memory entries, hdr_stall held high meanwhile.
// Depends on aclfrt_pkg, aclfrt_ctrl, aclfrt_dp and assert_macros.svh.
module acl_fragment_reassembly_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hdr_valid,
    output logic               hdr_stall,
    input  aclfrt_pkg::hdr_t   hdr,
    output logic               res_valid,
    input  logic               res_stall,
    output aclfrt_pkg::res_t   res
);
    import aclfrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    aclfrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    aclfrt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`include "assert_macros.svh"

    `ASSERT_IMP(a_no_res_in_clear, cmd.clr_en, !res_valid)
    `ASSERT_NXT(a_one_in_flight, hdr_valid && !hdr_stall, hdr_stall)
    `ASSERT_NXT(a_commit_loads, cmd.commit, res_valid)
    `ASSERT_IMP(a_action_legal, res_valid, res.action <= ACT_DROPPED)

endmodule
